>>> src/assert_macros.svh
// Assertion helper macros for the timer table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MSTT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSTT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSTT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define MSTT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> src/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg
// Types and codes shared by the timer table front end, queue and engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mstt_pkg;
  localparam logic [2:0] OP_SCHED_ONCE = 3'd0;
  localparam logic [2:0] OP_SCHED_REP  = 3'd1;
  localparam logic [2:0] OP_CANCEL     = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_CLEAR      = 3'd4;

  localparam logic [1:0] KIND_SCHED = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  typedef enum logic [2:0] {
    CMD_SCHED  = 3'b001,
    CMD_CANCEL = 3'b010,
    CMD_TICK   = 3'b100
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   cmd;
    logic        periodic;
    logic [31:0] interval;
    logic [31:0] tag;
    logic [15:0] cancel_id;
    logic [31:0] time_step;
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [31:0] tag;
    logic        periodic;
    logic        last;
  } res_t;
endpackage

>>> src/mstt_front.sv
// ----------------------------------------------------------------------------
// mstt_front
// Decodes opcodes into engine commands; clear, unknown codes and cancels of
// id zero are dropped here, clear being flagged to the engine directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mstt_front import mstt_pkg::*; (
  input  logic [2:0]  op,
  input  logic [31:0] interval,
  input  logic [31:0] tag,
  input  logic [15:0] cancel_id,
  input  logic [31:0] time_step,
  output logic        push,
  output logic        clear,
  output cmd_t        cmd
);
  always_comb begin
    push = 1'b1;
    clear = 1'b0;
    cmd.cmd = CMD_SCHED;
    cmd.periodic = (op == OP_SCHED_REP);
    cmd.interval = interval;
    cmd.tag = tag;
    cmd.cancel_id = cancel_id;
    cmd.time_step = time_step;
    unique case (op) inside
      OP_SCHED_ONCE, OP_SCHED_REP: cmd.cmd = CMD_SCHED;
      OP_CANCEL: begin
        cmd.cmd = CMD_CANCEL;
        push = (cancel_id != 16'd0);
      end
      OP_TICK: cmd.cmd = CMD_TICK;
      OP_CLEAR: begin
        push = 1'b0;
        clear = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end
endmodule

>>> src/mstt_queue.sv
// ----------------------------------------------------------------------------
// mstt_queue
// Two-entry command queue between the front end and the slot engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mstt_queue import mstt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic nonempty,
  output logic full,
  output cmd_t head
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign nonempty = (cnt_r != 2'd0);
  assign full = (cnt_r == 2'd2);
  assign head = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> src/mstt_engine.sv
// ----------------------------------------------------------------------------
// mstt_engine
// Walks the slot table one slot per cycle, while clear is low, for schedule, cancel and tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mstt_engine import mstt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic clear,
  input  logic cmd_vld,
  input  cmd_t cmd,
  output logic busy,
  output res_t res,
  output logic [$clog2(NUM_SLOTS+1)-1:0] count
);
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam logic [IW:0] LAST_IDX = (IW + 1)'(NUM_SLOTS - 1);

  logic [NUM_SLOTS-1:0] valid_r, per_r;
  logic [31:0] intv_r [NUM_SLOTS];
  logic [31:0] elap_r [NUM_SLOTS];
  logic [15:0] ident_r [NUM_SLOTS];
  logic [31:0] tag_r [NUM_SLOTS];
  logic [15:0] next_id_r;
  logic [CW-1:0] count_r;
  logic          run_r;
  logic [IW:0]   idx_r;
  res_t          res_r;

  logic [IW-1:0] s;
  logic [31:0]   e_sum;
  logic          fire, end_walk;
  logic [15:0]   nid;

  assign s = idx_r[IW-1:0];
  assign busy = run_r;
  assign res = res_r;
  assign count = count_r;
  assign nid = (next_id_r == 16'hFFFF) ? 16'd1 : next_id_r + 16'd1;

  always_comb begin
    logic [32:0] t;
    t = {1'b0, elap_r[s]} + {1'b0, cmd.time_step};
    e_sum = t[32] ? 32'hFFFF_FFFF : t[31:0];
    fire = valid_r[s] && (e_sum >= intv_r[s]);
    end_walk = (idx_r == LAST_IDX);
  end

  // Payload of the slot entries; elapsed updates during tick, but not in the
  // closing cycle, where the slot index has run past the table.
  always_ff @(posedge clk) begin
    if (run_r && cmd.cmd == CMD_SCHED && !valid_r[s]) begin
      intv_r[s] <= cmd.interval;
      elap_r[s] <= 32'd0;
      tag_r[s] <= cmd.tag;
      ident_r[s] <= next_id_r;
    end
    if (run_r && cmd.cmd == CMD_TICK && valid_r[s] && idx_r <= LAST_IDX) begin
      elap_r[s] <= fire ? 32'd0 : e_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      per_r <= '0;
      next_id_r <= 16'd1;
      count_r <= '0;
      run_r <= 1'b0;
      idx_r <= '0;
      res_r <= '0;
    end else begin
      res_r.valid <= 1'b0;
      if (clear) begin
        valid_r <= '0;
        count_r <= '0;
      end else if (!run_r) begin
        if (cmd_vld) begin
          run_r <= 1'b1;
          idx_r <= '0;
        end
      end else begin
        idx_r <= idx_r + 1'b1;
        unique case (cmd.cmd)
          CMD_SCHED: begin
            if (!valid_r[s]) begin
              valid_r[s] <= 1'b1;
              per_r[s] <= cmd.periodic;
              next_id_r <= nid;
              count_r <= count_r + 1'b1;
              run_r <= 1'b0;
              res_r <= '{1'b1, KIND_SCHED, next_id_r, 32'd0, 1'b0, 1'b1};
            end else if (end_walk) begin
              run_r <= 1'b0;
              res_r <= '{1'b1, KIND_SCHED, 16'd0, 32'd0, 1'b0, 1'b1};
            end
          end
          CMD_CANCEL: begin
            if (valid_r[s] && ident_r[s] == cmd.cancel_id) begin
              valid_r[s] <= 1'b0;
              count_r <= count_r - 1'b1;
              run_r <= 1'b0;
            end else if (end_walk) run_r <= 1'b0;
          end
          CMD_TICK: begin
            if (idx_r > LAST_IDX) begin
              run_r <= 1'b0;
              res_r <= '{1'b1, KIND_DONE, 16'd0, 32'd0, 1'b0, 1'b1};
            end else if (fire) begin
              if (!per_r[s]) begin
                valid_r[s] <= 1'b0;
                count_r <= count_r - 1'b1;
              end
              res_r <= '{1'b1, KIND_FIRED, ident_r[s], tag_r[s], per_r[s], 1'b0};
            end
          end
          default: run_r <= 1'b0;
        endcase
      end
    end
  end
endmodule

>>> src/multi_slot_timer_table_unit.sv
// ----------------------------------------------------------------------------
// multi_slot_timer_table_unit
// Table of one-shot and periodic timers with schedule, cancel, tick, clear.
// ----------------------------------------------------------------------------
// Channel   Ports                    Handshake
// input     in_*                     start && !busy
// result    out_*                    out_valid, one cycle
//
// Commands wait in a two-beat queue. The engine takes each one from the queue
// head and walks the slots one per cycle; its entry is released once the
// walk ends. Schedule and cancel stop at the first hit or at the end of the
// table; tick walks all NUM_SLOTS slots and then issues its closing beat.
// Clear acts at the edge that accepts it. Reset sets every slot free and the
// next id to one. busy is high while the command queue is full, and for a
// clear until queue and engine are idle; results cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module multi_slot_timer_table_unit import mstt_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_interval,
  input  logic [31:0] in_callback_tag,
  input  logic [15:0] in_cancel_id,
  input  logic [31:0] in_time_step,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [15:0] out_timer_id,
  output logic [31:0] out_tag_out,
  output logic        out_was_periodic,
  output logic [4:0]  out_active_count,
  output logic        out_last
);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  logic f_push, f_clear, q_ne, q_full, pop, eng_busy;
  cmd_t f_cmd, q_head;
  res_t res;
  logic [CW-1:0] cnt;
  logic acc;

  // Clear must not overtake queued commands, so hold it off until drained.
  assign busy = q_full || (in_opcode == OP_CLEAR && (q_ne || eng_busy));
  assign acc = start && !busy;

  mstt_front u_front (
    .op(in_opcode), .interval(in_interval), .tag(in_callback_tag),
    .cancel_id(in_cancel_id), .time_step(in_time_step),
    .push(f_push), .clear(f_clear), .cmd(f_cmd)
  );

  mstt_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(acc && f_push), .push_cmd(f_cmd),
    .pop(pop), .nonempty(q_ne), .full(q_full), .head(q_head)
  );

  // The engine keeps its command at the queue head until the walk ends; in
  // the cycle that releases the head it must not start on it again.
  mstt_engine #(.NUM_SLOTS(NUM_SLOTS)) u_engine (
    .clk(clk), .rst_n(rst_n), .clear(acc && f_clear), .cmd_vld(q_ne && !pop),
    .cmd(q_head), .busy(eng_busy), .res(res), .count(cnt)
  );

  logic eng_busy_q;
  always_ff @(posedge clk) begin
    if (!rst_n) eng_busy_q <= 1'b0;
    else eng_busy_q <= eng_busy;
  end
  assign pop = eng_busy_q && !eng_busy;

  assign out_valid = res.valid;
  assign out_kind = res.kind;
  assign out_timer_id = res.timer_id;
  assign out_tag_out = res.tag;
  assign out_was_periodic = res.periodic;
  assign out_active_count = 5'(cnt);
  assign out_last = res.last;

  `MSTT_ASSERT_IMPL(a_last_kind, clk, rst_n, out_valid && out_kind == KIND_DONE |-> out_last, "done not last")
  `MSTT_ASSERT_IMPL(a_fired_not_last, clk, rst_n, out_valid && out_kind == KIND_FIRED |-> !out_last, "fired last")
  `MSTT_ASSERT_IMPL(a_count_range, clk, rst_n, cnt <= CW'(NUM_SLOTS), "count out of range")
endmodule

>>> bench/multi_slot_timer_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table result checker
// Watches the command and result channels of the timer table, keeps its own
// copy of the slot table, predicts every result beat and compares it in order.
// ----------------------------------------------------------------------------
module multi_slot_timer_table_checker import mstt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_interval,
  input  logic [31:0] in_callback_tag,
  input  logic [15:0] in_cancel_id,
  input  logic [31:0] in_time_step,
  input  logic        out_valid,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_timer_id,
  input  logic [31:0] out_tag_out,
  input  logic        out_was_periodic,
  input  logic [4:0]  out_active_count,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  localparam int SLOTS = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [31:0] tag;
    logic        periodic;
    logic [4:0]  active;
    logic        last;
  } beat_t;

  logic        live [SLOTS];
  logic        repeating [SLOTS];
  logic [31:0] period [SLOTS];
  logic [31:0] elapsed [SLOTS];
  logic [15:0] ident [SLOTS];
  logic [31:0] cb_tag [SLOTS];
  logic [15:0] fresh_id;
  beat_t       due_beats [$];

  function automatic logic [4:0] live_total();
    logic [4:0] n;
    n = 0;
    for (int s = 0; s < SLOTS; s++) n += live[s];
    return n;
  endfunction

  task automatic push_beat(logic [1:0] k, logic [15:0] id, logic [31:0] t, logic p,
                           logic l);
    beat_t b;
    b = '{k, id, t, p, live_total(), l};
    due_beats.push_back(b);
  endtask

  task automatic apply_command();
    logic [15:0] id;
    logic [32:0] sum;
    logic        p;
    bit          done;
    done = 0;
    id = 0;
    case (in_opcode) inside
      OP_SCHED_ONCE, OP_SCHED_REP: begin
        for (int s = 0; s < SLOTS && !done; s++) begin
          if (!live[s]) begin
            live[s] = 1;
            repeating[s] = (in_opcode == OP_SCHED_REP);
            period[s] = in_interval;
            elapsed[s] = 0;
            cb_tag[s] = in_callback_tag;
            ident[s] = fresh_id;
            id = fresh_id;
            fresh_id = (fresh_id == 16'hFFFF) ? 16'd1 : fresh_id + 16'd1;
            done = 1;
          end
        end
        push_beat(KIND_SCHED, id, 0, 0, 1);
      end
      OP_CANCEL: begin
        if (in_cancel_id != 0) begin
          for (int s = 0; s < SLOTS && !done; s++) begin
            if (live[s] && ident[s] == in_cancel_id) begin
              live[s] = 0;
              done = 1;
            end
          end
        end
      end
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (live[s]) begin
            sum = {1'b0, elapsed[s]} + {1'b0, in_time_step};
            elapsed[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (elapsed[s] >= period[s]) begin
              p = repeating[s];
              if (p) elapsed[s] = 0;
              else live[s] = 0;
              push_beat(KIND_FIRED, ident[s], cb_tag[s], p, 0);
            end
          end
        end
        push_beat(KIND_DONE, 0, 0, 0, 1);
      end
      OP_CLEAR: begin
        for (int s = 0; s < SLOTS; s++) begin
          live[s] = 0;
          elapsed[s] = 0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    beat_t want;
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        live[s] = 0;
        repeating[s] = 0;
      end
      fresh_id = 16'd1;
      due_beats.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (due_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d id %0d", out_kind,
                 out_timer_id);
          fail_count <= fail_count + 1;
        end else begin
          want = due_beats.pop_front();
          if (want.kind !== out_kind ||
              want.timer_id !== out_timer_id ||
              want.tag !== out_tag_out ||
              want.periodic !== out_was_periodic ||
              want.active !== out_active_count ||
              want.last !== out_last) begin
            fail_count <= fail_count + 1;
            if (want.kind !== out_kind)
              $error("kind: expected %0d, got %0d", want.kind, out_kind);
            if (want.timer_id !== out_timer_id)
              $error("timer_id: expected %0d, got %0d", want.timer_id, out_timer_id);
            if (want.tag !== out_tag_out)
              $error("tag_out: expected %h, got %h", want.tag, out_tag_out);
            if (want.periodic !== out_was_periodic)
              $error("was_periodic: expected %0d, got %0d", want.periodic,
                     out_was_periodic);
            if (want.active !== out_active_count)
              $error("active_count: expected %0d, got %0d", want.active,
                     out_active_count);
            if (want.last !== out_last)
              $error("last: expected %0d, got %0d", want.last, out_last);
          end
        end
      end
      // Commands are applied after the result beat of this edge is checked,
      // since a result can never be caused by a command accepted at the same edge.
      if (start && !busy) apply_command();
    end
    pending_count <= due_beats.size();
  end
endmodule

>>> bench/multi_slot_timer_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table testbench
// Drives directed and random schedule, cancel, tick, clear and unknown commands into
// the timer table; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module multi_slot_timer_table_unit_tb import mstt_pkg::*;;
  localparam int IDLE_LIMIT = 5000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  in_opcode = OP_CLEAR;
  logic [31:0] in_interval = 0;
  logic [31:0] in_callback_tag = 0;
  logic [15:0] in_cancel_id = 0;
  logic [31:0] in_time_step = 0;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [15:0] out_timer_id;
  logic [31:0] out_tag_out;
  logic        out_was_periodic;
  logic [4:0]  out_active_count;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          quiet_cycles = 0;
  logic [15:0] issued_ids [$];
  bit          calm = 0;

  always #5 clk = ~clk;

  multi_slot_timer_table_unit dut (.*);

  multi_slot_timer_table_checker chk (.*);

  // Watchdog on cycles with no accepted beat in either direction.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Record handed-out ids so that cancels mostly target ids that were issued.
  always @(posedge clk)
    if (rst_n && out_valid && out_kind == KIND_SCHED && out_timer_id != 0)
      issued_ids.push_back(out_timer_id);

  // start is lowered only on idle cycles, so that back-to-back beats keep it
  // high without a second assignment in the same step.
  task automatic send(logic [2:0] op, logic [31:0] iv, logic [31:0] tg, logic [15:0] cid,
                      logic [31:0] st);
    if (!calm) begin
      while ($urandom_range(99) < 7) begin
        start <= 0;
        @(posedge clk);
      end
    end
    start <= 1;
    in_opcode <= op;
    in_interval <= iv;
    in_callback_tag <= tg;
    in_cancel_id <= cid;
    in_time_step <= st;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(5))
      0: return 0;
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom;
      default: return $urandom_range(40);
    endcase
  endfunction

  task automatic random_command();
    int r;
    logic [15:0] cid;
    r = $urandom_range(99);
    if (r < 35) send($urandom_range(1) ? OP_SCHED_REP : OP_SCHED_ONCE, pick_time(),
                     $urandom, 0, 0);
    else if (r < 50) begin
      if (issued_ids.size() > 0 && $urandom_range(3) != 0)
        cid = issued_ids[$urandom_range(issued_ids.size() - 1)];
      else
        cid = $urandom;
      send(OP_CANCEL, $urandom, $urandom, cid, $urandom);
    end
    else if (r < 92) send(OP_TICK, $urandom, $urandom, $urandom, pick_time());
    else if (r < 96) send(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    else send(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every opcode, zero interval, saturation, full table.
    send(OP_TICK, 0, 0, 0, 0);
    send(OP_SCHED_ONCE, 0, 32'hFFFF_FFFF, 0, 0);
    send(OP_SCHED_REP, 0, 32'h0000_0001, 0, 0);
    send(OP_SCHED_REP, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0, 0);
    send(OP_TICK, 0, 0, 0, 0);
    send(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send(OP_TICK, 0, 0, 0, 32'hFFFF_FFFF);
    send(OP_CANCEL, 0, 0, 0, 0);
    send(OP_CANCEL, 0, 0, 16'hFFFF, 0);
    send(OP_CANCEL, 0, 0, 16'd2, 0);
    send(3'd5, 0, 0, 0, 0);
    send(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) send(OP_SCHED_ONCE, 32'd10 + i, 32'h100 + i, 0, 0);
    send(OP_TICK, 0, 0, 0, 32'd30);
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_TICK, 0, 0, 0, 32'd1);

    for (int i = 0; i < 198; i++) begin
      calm = (i >= 80 && i < 130);
      random_command();
    end
    calm = 0;
    start <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
